[rtl/core/plucked_string_synth_defines.svh]
// assertion macros shared by the plucked string synthesizer rtl
// expects a clock named clock and a synchronous reset named reset in scope
`ifndef PLUCKED_STRING_SYNTH_DEFINES_SVH
`define PLUCKED_STRING_SYNTH_DEFINES_SVH

// check that is ignored while reset is high
`define PSS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("plucked_string_synth assertion failed");

// check that also holds across reset
`define PSS_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("plucked_string_synth assertion failed");

`endif

[rtl/core/pss_pkg.sv]
// shared types and constants for the plucked string synthesizer
// no dependencies; used by pss_blend and plucked_string_synth
`default_nettype none

package pss_pkg;

   // default sizes of the tone ring and audio samples
   localparam int DELAY_DEPTH_DEFAULT  = 2048;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;

   // request item field widths
   localparam int PERIOD_WIDTH    = 12;
   localparam int DAMPING_WIDTH   = 16;
   localparam int NOISE_WIDTH     = 15;
   localparam int REQ_TDATA_WIDTH = 48;
   localparam int REQ_TUSER_WIDTH = 2;

   // samples-in-note counter, saturating
   localparam int PHASE_WIDTH = 12;
   localparam logic [PHASE_WIDTH-1:0] PHASE_MAX = '1;

   // where a sample comes from
   typedef enum logic [1:0] {
      SRC_REST,
      SRC_NOISE,
      SRC_DAMPED
   } src_type;

endpackage

`default_nettype wire

[rtl/core/pss_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module pss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/core/pss_blend.sv]
// sample select and damped blend of the previous and the delayed sample
// depends on pss_pkg
`default_nettype none

module pss_blend #(
   parameter int SAMPLE_WIDTH = pss_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire pss_pkg::src_type               src,
   input  wire logic signed [SAMPLE_WIDTH-1:0] x,
   input  wire logic signed [SAMPLE_WIDTH-1:0] y,
   input  wire logic [pss_pkg::DAMPING_WIDTH-1:0] damping,
   input  wire logic [pss_pkg::NOISE_WIDTH-1:0]   noise,
   output logic signed [SAMPLE_WIDTH-1:0]      sample
);

   import pss_pkg::*;

   localparam int SMAX_INT = 2 ** (SAMPLE_WIDTH - 1) - 1;
   localparam logic signed [SAMPLE_WIDTH+1:0] SMAX_W = (SAMPLE_WIDTH+2)'(SMAX_INT);
   localparam logic signed [SAMPLE_WIDTH+1:0] SMIN_W = (SAMPLE_WIDTH+2)'(-SMAX_INT - 1);

   logic signed [SAMPLE_WIDTH:0]               diff;
   logic signed [DAMPING_WIDTH:0]              weight;
   logic signed [SAMPLE_WIDTH+DAMPING_WIDTH+1:0] prod;
   logic signed [SAMPLE_WIDTH+1:0]             step;
   logic signed [SAMPLE_WIDTH+1:0]             sum;

   // y + floor(damping * (x - y) / 2^16)
   assign diff   = (SAMPLE_WIDTH+1)'(x) - (SAMPLE_WIDTH+1)'(y);
   assign weight = $signed({1'b0, damping});
   assign prod   = weight * diff;
   assign step   = (SAMPLE_WIDTH+2)'(prod >>> DAMPING_WIDTH);
   assign sum    = (SAMPLE_WIDTH+2)'(y) + step;

   // pick the source and saturate to the sample range
   always_comb begin
      case (src)
         SRC_REST: begin
            sample = '0;
         end
         SRC_NOISE: begin
            if (32'(noise) > 32'(SMAX_INT)) begin
               sample = SAMPLE_WIDTH'(SMAX_W);
            end else begin
               sample = SAMPLE_WIDTH'(noise);
            end
         end
         SRC_DAMPED: begin
            if (sum > SMAX_W) begin
               sample = SAMPLE_WIDTH'(SMAX_W);
            end else if (sum < SMIN_W) begin
               sample = SAMPLE_WIDTH'(SMIN_W);
            end else begin
               sample = SAMPLE_WIDTH'(sum);
            end
         end
         default: begin
            sample = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/plucked_string_synth.sv]
// Plucked string tone generator: one signed audio sample out for every request item, at a
// sustained rate of one item per clock cycle while no result waits on rsp_tready. Accepting
// an item registers it and reads the tone ring (a synchronous-read RAM of DELAY_DEPTH
// samples); the registered item then forms the sample with one multiply and loads the result
// register while writing the sample back into the ring. A result waiting on rsp_tready holds
// the registered item, and a held item stops the next item from being accepted. The ring
// needs no clearing after reset: during the first period of a note the output is the noise
// value, so the ring is only read at entries already written.
// depends on pss_pkg, pss_ram, pss_blend and plucked_string_synth_defines.svh
`default_nettype none
`include "plucked_string_synth_defines.svh"

module plucked_string_synth #(
   parameter int DELAY_DEPTH  = pss_pkg::DELAY_DEPTH_DEFAULT,
   parameter int SAMPLE_WIDTH = pss_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // period [11:0], damping [27:12], noise [42:28], zero above
   input  wire logic [pss_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // note_start [0], rest [1]
   input  wire logic [pss_pkg::REQ_TUSER_WIDTH-1:0] req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // sample [SAMPLE_WIDTH-1:0], zero above
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   import pss_pkg::*;

   localparam int AW    = $clog2(DELAY_DEPTH);
   localparam int CW    = AW + 1;
   localparam int RSP_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   typedef struct packed {
      src_type                  src;
      logic [AW-1:0]            wp;
      logic                     is_p1;
      logic [DAMPING_WIDTH-1:0] damping;
      logic [NOISE_WIDTH-1:0]   noise;
   } stage_type;

   // request fields
   logic                     req_start;
   logic                     req_rest;
   logic [PERIOD_WIDTH-1:0]  req_period;
   logic [DAMPING_WIDTH-1:0] req_damping;
   logic [NOISE_WIDTH-1:0]   req_noise;

   assign req_start   = req_tuser[0];
   assign req_rest    = req_tuser[1];
   assign req_period  = req_tdata[PERIOD_WIDTH-1:0];
   assign req_damping = req_tdata[PERIOD_WIDTH +: DAMPING_WIDTH];
   assign req_noise   = req_tdata[PERIOD_WIDTH+DAMPING_WIDTH +: NOISE_WIDTH];

   // registers
   logic                           s1_valid_ff, s1_valid_in;
   stage_type                      s1_ff, s1_in;
   logic [AW-1:0]                  rd_wp_ff, rd_wp_in;
   logic [PHASE_WIDTH-1:0]         phase_ff, phase_in;
   logic signed [SAMPLE_WIDTH-1:0] last_ff, last_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff;

   logic                           req_acc;
   logic                           s1_adv;
   logic [CW-1:0]                  per_cl;
   logic [PHASE_WIDTH-1:0]         count;
   logic                           noise_phase;
   logic [CW-1:0]                  rd_diff;
   logic [AW-1:0]                  rd_addr;
   logic signed [SAMPLE_WIDTH-1:0] ram_q;
   logic signed [SAMPLE_WIDTH-1:0] x_sel;
   logic signed [SAMPLE_WIDTH-1:0] blend_sample;

   // handshake
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'($unsigned(rsp_data_ff));

   // period clamp to 1 .. DELAY_DEPTH
   always_comb begin
      if (req_period == '0) begin
         per_cl = CW'(1);
      end else if (32'(req_period) > 32'(DELAY_DEPTH)) begin
         per_cl = CW'(DELAY_DEPTH);
      end else begin
         per_cl = CW'(req_period);
      end
   end

   // samples-in-note count and noise phase test
   assign count       = req_start ? '0 : phase_ff;
   assign phase_in    = (count == PHASE_MAX) ? PHASE_MAX : count + 1'b1;
   assign noise_phase = 32'(count) < 32'(per_cl);

   // ring read address, one period behind the write pointer
   assign rd_diff = {1'b0, rd_wp_ff} - per_cl;
   assign rd_addr = rd_diff[AW] ? AW'(rd_diff + CW'(DELAY_DEPTH)) : rd_diff[AW-1:0];
   assign rd_wp_in = (rd_wp_ff == AW'(DELAY_DEPTH - 1)) ? '0 : rd_wp_ff + 1'b1;

   // item captured into the first stage
   always_comb begin
      s1_in.wp      = rd_wp_ff;
      s1_in.is_p1   = (per_cl == CW'(1));
      s1_in.damping = req_damping;
      s1_in.noise   = req_noise;
      if (req_rest) begin
         s1_in.src = SRC_REST;
      end else if (noise_phase) begin
         s1_in.src = SRC_NOISE;
      end else begin
         s1_in.src = SRC_DAMPED;
      end
   end

   // tone ring
   pss_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (DELAY_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_ff.wp),
      .wr_data (blend_sample),
      .rd_en   (req_acc),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // a period of one reads the sample written just before
   assign x_sel = s1_ff.is_p1 ? last_ff : ram_q;

   pss_blend #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_blend (
      .src     (s1_ff.src),
      .x       (x_sel),
      .y       (last_ff),
      .damping (s1_ff.damping),
      .noise   (s1_ff.noise),
      .sample  (blend_sample)
   );

   // next-state for control
   assign s1_valid_in  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign last_in      = s1_adv ? blend_sample : last_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_wp_ff     <= '0;
         phase_ff     <= '0;
         last_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         if (req_acc) begin
            rd_wp_ff <= rd_wp_in;
            phase_ff <= phase_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_data_ff <= blend_sample;
      end
   end

   // checks
   `PSS_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid_ff)
   `PSS_ASSERT(a_last_matches_rsp, rsp_valid_ff |-> (last_ff == rsp_data_ff))
   `PSS_ASSERT(a_rest_gives_zero,
      (s1_adv && (s1_ff.src == SRC_REST)) |=> (rsp_data_ff == '0))
   `PSS_ASSERT(a_pointer_lead, s1_valid_ff |-> ((s1_ff.wp == AW'(DELAY_DEPTH - 1)) ?
      (rd_wp_ff == '0) : (rd_wp_ff == AW'(s1_ff.wp + 1'b1))))

endmodule

`default_nettype wire
